### hw/rtl/piecewise_linear_interpolator_unit_macros.svh
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_unit_macros
// Assertion macros used by the interpolator unit RTL.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_UNIT_MACROS_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_UNIT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define PLI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define PLI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hw/rtl/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg
// Shared types and codes for the piecewise linear interpolator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pli_pkg;

    localparam logic [1:0] KIND_INTERP = 2'd0;
    localparam logic [1:0] KIND_ADD    = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;
    localparam logic [1:0] KIND_RSVD   = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_REQ,
        ST_SCAN_CHK,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_INSERT,
        ST_SEG_RD,
        ST_DIV,
        ST_MUL,
        ST_FINISH,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;

endpackage

### hw/rtl/piecewise_linear_interpolator_unit.sv
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_unit
// An interpolate item scans the table entries in order and gives a clamped or exact
// result from them, or interpolates between two entries through the divider.
// An add item replaces the entry with the same x, or inserts, shifting later entries up;
// clear and unused items need no table access.
// Throughput: one item at a time; the next is taken the cycle after a result is registered.
// Reset: asynchronous, active low; empties the table, no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "piecewise_linear_interpolator_unit_macros.svh"

module piecewise_linear_interpolator_unit #(
    parameter int MAX_POINTS   = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     kind,
    input  logic signed [SAMPLE_WIDTH-1:0] x_value,
    input  logic signed [SAMPLE_WIDTH-1:0] y_value,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] y_out,
    output logic                           status
);
    import pli_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int SW = SAMPLE_WIDTH;
    localparam int DW = SW + 1;
    localparam int NW = 2 * SW + 2;

    // Memory holds {x, y} per entry.
    logic [2*SW-1:0] mem [MAX_POINTS];
    logic [2*SW-1:0] rd_data_reg;
    logic [AW-1:0]   rd_addr;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [2*SW-1:0] wr_data;

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [1:0]    kind_reg;
    logic signed [SW-1:0] xq_reg, yq_reg;
    logic signed [SW-1:0] x0_reg, y0_reg, x0_next, y0_next;
    logic signed [SW-1:0] res_reg, res_next;
    logic          st_reg, st_next;
    logic          ov_reg;
    logic signed [SW-1:0] y_out_reg;
    logic          status_reg;
    logic signed [NW-1:0] prod_reg;
    logic signed [DW-1:0] dx_reg;
    logic          div_start;
    div_ctl_t      dctl;
    logic signed [NW-1:0] quot;
    logic signed [SW-1:0] rx, ry;
    logic          accept;
    logic          out_load;

    assign rx = rd_data_reg[2*SW-1:SW];
    assign ry = rd_data_reg[SW-1:0];
    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    // A finished result moves to the output register once that register is free.
    assign out_load = (state_reg == ST_OUT) && (!ov_reg || !out_stall);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    if (kind == KIND_INTERP && count_reg != '0)
                        state_next = ST_SCAN_REQ;
                    else if (kind == KIND_ADD)
                        state_next = (count_reg == '0) ? ST_INSERT : ST_SCAN_REQ;
                    else
                        state_next = ST_FINISH;
                end
            ST_SCAN_REQ: state_next = ST_SCAN_CHK;
            ST_SCAN_CHK:
                if (kind_reg == KIND_ADD)
                begin
                    if (rx == xq_reg)
                        state_next = ST_FINISH;
                    else if (rx > xq_reg || idx_reg == count_reg - 1'b1)
                    begin
                        if (count_reg == CW'(MAX_POINTS))
                            state_next = ST_FINISH;
                        else if (rx > xq_reg)
                            state_next = ST_SHIFT_RD;
                        else
                            state_next = ST_INSERT;
                    end
                    else
                        state_next = ST_SCAN_REQ;
                end
                else
                begin
                    if (idx_reg == '0 && xq_reg <= rx)
                        state_next = ST_FINISH;
                    else if (rx == xq_reg)
                        state_next = ST_FINISH;
                    else if (rx > xq_reg)
                        state_next = ST_SEG_RD;
                    else if (idx_reg == count_reg - 1'b1)
                        state_next = ST_FINISH;
                    else
                        state_next = ST_SCAN_REQ;
                end
            ST_SHIFT_RD: state_next = ST_SHIFT_WR;
            ST_SHIFT_WR: state_next = ST_SHIFT_RD;
            ST_INSERT:   state_next = ST_FINISH;
            ST_SEG_RD:   state_next = ST_MUL;
            ST_MUL:      state_next = ST_DIV;
            ST_DIV:      state_next = dctl.done ? ST_FINISH : ST_DIV;
            ST_FINISH:   state_next = ST_OUT;
            ST_OUT:      state_next = out_load ? ST_IDLE : ST_OUT;
            default:     state_next = ST_IDLE;
        endcase
        if (state_reg == ST_SHIFT_WR && idx_next == idx_reg)
            state_next = ST_INSERT;
    end

    // Insertion index; during the shift, idx walks down from count to it.
    logic [CW-1:0] ins_reg, ins_next;

    always_comb
    begin
        count_next = count_reg;
        idx_next   = idx_reg;
        ins_next   = ins_reg;
        x0_next    = x0_reg;
        y0_next    = y0_reg;
        res_next   = res_reg;
        st_next    = st_reg;
        rd_addr    = idx_reg[AW-1:0];
        wr_en      = 1'b0;
        wr_addr    = idx_reg[AW-1:0];
        wr_data    = {xq_reg, yq_reg};
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                ins_next = '0;
                res_next = '0;
                st_next  = 1'b0;
                if (accept && kind == KIND_CLEAR)
                    count_next = '0;
            end
            ST_SCAN_REQ: ;
            ST_SCAN_CHK:
            begin
                x0_next = rx;
                y0_next = ry;
                if (kind_reg == KIND_ADD)
                begin
                    if (rx == xq_reg)
                    begin
                        wr_en = 1'b1;
                    end
                    else if (rx > xq_reg || idx_reg == count_reg - 1'b1)
                    begin
                        if (count_reg == CW'(MAX_POINTS))
                            st_next = 1'b1;
                        else if (rx > xq_reg)
                        begin
                            ins_next = idx_reg;
                            idx_next = count_reg;
                        end
                        else
                            idx_next = count_reg;
                    end
                    else
                        idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    if ((idx_reg == '0 && xq_reg <= rx) || rx == xq_reg)
                        res_next = ry;
                    else if (rx > xq_reg)
                        ;
                    else if (idx_reg == count_reg - 1'b1)
                        res_next = ry;
                    else
                        idx_next = idx_reg + 1'b1;
                end
            end
            ST_SHIFT_RD:
                rd_addr = AW'(idx_reg - 1'b1);
            ST_SHIFT_WR:
            begin
                wr_en    = 1'b1;
                wr_data  = rd_data_reg;
                idx_next = idx_reg - 1'b1;
                if (idx_reg - 1'b1 == ins_reg)
                    idx_next = idx_reg - 1'b1;
            end
            ST_INSERT:
            begin
                wr_en      = 1'b1;
                count_next = count_reg + 1'b1;
            end
            ST_SEG_RD:
                rd_addr = AW'(idx_reg - 1'b1);
            ST_MUL:
                rd_addr = AW'(idx_reg - 1'b1);
            ST_DIV:
            begin
                // Keep the lower point on the read port; its y is the base of the result.
                rd_addr   = AW'(idx_reg - 1'b1);
                div_start = !dctl.busy && !dctl.done;
                if (dctl.done)
                    res_next = SW'(rd_data_reg[SW-1:0] + SW'(quot));
            end
            ST_FINISH: ;
            ST_OUT: ;
            default: ;
        endcase
    end

    // Leave the shift loop once the slot at the insertion index is vacated.
    logic shift_last;
    assign shift_last = (state_reg == ST_SHIFT_WR) && (idx_reg - 1'b1 == ins_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= shift_last ? ST_INSERT : state_next;
            count_reg <= count_next;
            if (out_load)
                ov_reg <= 1'b1;
            else if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= shift_last ? ins_reg : idx_next;
        ins_reg <= ins_next;
        x0_reg  <= x0_next;
        y0_reg  <= y0_next;
        res_reg <= res_next;
        st_reg  <= st_next;
        if (accept)
        begin
            kind_reg <= kind;
            xq_reg   <= x_value;
            yq_reg   <= y_value;
        end
        // x0/y0 hold the upper point here, rd_data holds the lower one.
        if (state_reg == ST_MUL)
        begin
            dx_reg <= DW'(x0_reg) - DW'(rx);
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= NW'(DW'(xq_reg) - DW'(rx)) * NW'(DW'(y0_reg) - DW'(ry));
        end
        if (out_load)
        begin
            y_out_reg  <= res_reg;
            status_reg <= st_reg;
        end
    end

    pli_divider #(
        .NW(NW),
        .DW(DW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (prod_reg),
        .denom (dx_reg),
        .ctl   (dctl),
        .quot  (quot)
    );

    assign out_valid = ov_reg;
    assign y_out     = y_out_reg;
    assign status    = status_reg;

    `PLI_ASSERT_IMP(a_stall_busy, clk, rst_n, state_reg != ST_IDLE, in_stall)
    `PLI_ASSERT_IMP(a_count_max, clk, rst_n, 1'b1, count_reg <= CW'(MAX_POINTS))
    `PLI_ASSERT_NEXT(a_clear, clk, rst_n, accept && kind == KIND_CLEAR, count_reg == '0)
    `PLI_ASSERT_IMP(a_div_idle, clk, rst_n, dctl.busy, state_reg == ST_DIV)

endmodule

### hw/rtl/pli_divider.sv
// ----------------------------------------------------------------------------
// pli_divider
// Restoring signed divider, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pli_divider #(
    parameter int NW = 48,
    parameter int DW = 17
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [NW-1:0] numer,
    input  logic signed [DW-1:0] denom,
    output pli_pkg::div_ctl_t    ctl,
    output logic signed [NW-1:0] quot
);
    import pli_pkg::*;

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   r_reg, r_next;
    logic [DW-1:0] d_reg;
    logic          neg_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    logic [DW:0]   trial;
    logic [DW:0]   shifted;

    always_comb
    begin
        shifted = {r_reg[DW-1:0], q_reg[NW-1]};
        trial   = shifted - {1'b0, d_reg};
        q_next  = {q_reg[NW-2:0], ~trial[DW]};
        r_next  = trial[DW] ? shifted : trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= numer[NW-1] ? NW'(-numer) : numer;
            d_reg   <= denom[DW-1] ? DW'(-denom) : denom;
            r_reg   <= '0;
            neg_reg <= numer[NW-1] ^ denom[DW-1];
        end
        else if (busy_reg)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign quot      = neg_reg ? NW'(-q_reg) : q_reg;
    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;

endmodule
